[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_POPPED    = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] item_value;
		logic signed [15:0] item_priority;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] popped_value;
		logic [4:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds an entry, compares it with the incoming priority
// and shifts right on insert or left on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire logic                  clk,
	input  wire spq_pkg::cell_ctl_t    ctl,
	input  wire logic                  occupied,
	input  wire logic signed [31:0]    new_value,
	input  wire logic signed [15:0]    new_priority,
	input  wire logic                  left_ge,
	input  wire logic signed [31:0]    left_value,
	input  wire logic signed [15:0]    left_priority,
	input  wire logic signed [31:0]    right_value,
	input  wire logic signed [15:0]    right_priority,
	output logic                       ge,
	output logic signed [31:0]         value,
	output logic signed [15:0]         priority_val
);
	import spq_pkg::*;

	logic signed [31:0] value_q;
	logic signed [15:0] priority_q;

	// entry stays ahead of the newcomer
	assign ge = occupied && (priority_q <= new_priority);

	always_ff @(posedge clk) begin
		if (ctl.ins && !ge) begin
			if (left_ge) begin
				value_q    <= new_value;
				priority_q <= new_priority;
			end else begin
				value_q    <= left_value;
				priority_q <= left_priority;
			end
		end else if (ctl.pop) begin
			value_q    <= right_value;
			priority_q <= right_priority;
		end
	end

	assign value        = value_q;
	assign priority_val = priority_q;

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held in a row of compare-and-shift cells.
// The response is valid in the cycle after the request transfer.
// Throughput: one item per cycle while no held response blocks req_ready;
// all cells compare and shift in parallel. Reset clears the entry count and
// the response valid flag; cell contents and response payload are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire spq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output spq_pkg::rsp_t      rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]   count_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               accept;
	logic               full;
	logic               empty;
	cell_ctl_t          ctl;
	logic [CNT_W-1:0]   count_nxt;
	rsp_t               rsp_nxt;
	logic [CNT_W+4:0]   count_ext;

	logic               ge       [CAPACITY];
	logic signed [31:0] cell_val [CAPACITY];
	logic signed [15:0] cell_pri [CAPACITY];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);

	assign ctl.ins = accept && (req.kind == KIND_INSERT) && !full;
	assign ctl.pop = accept && (req.kind == KIND_POP) && !empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic               lge;
		logic signed [31:0] lval;
		logic signed [15:0] lpri;
		logic signed [31:0] rval;
		logic signed [15:0] rpri;

		if (i == 0) begin : g_head
			assign lge  = 1'b1;
			assign lval = req.item_value;
			assign lpri = req.item_priority;
		end else begin : g_mid
			assign lge  = ge[i-1];
			assign lval = cell_val[i-1];
			assign lpri = cell_pri[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rval = cell_val[i];
			assign rpri = cell_pri[i];
		end else begin : g_body
			assign rval = cell_val[i+1];
			assign rpri = cell_pri[i+1];
		end

		spq_cell u_cell (
			.clk            (clk),
			.ctl            (ctl),
			.occupied       (count_q > CNT_W'(i)),
			.new_value      (req.item_value),
			.new_priority   (req.item_priority),
			.left_ge        (lge),
			.left_value     (lval),
			.left_priority  (lpri),
			.right_value    (rval),
			.right_priority (rpri),
			.ge             (ge[i]),
			.value          (cell_val[i]),
			.priority_val   (cell_pri[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign count_ext = {5'd0, count_nxt};

	always_comb begin
		rsp_nxt.popped_value = '0;
		rsp_nxt.occupancy    = count_ext[4:0];
		if (req.kind == KIND_INSERT) begin
			rsp_nxt.status = full ? ST_OVERFLOW : ST_INSERTED;
		end else if (empty) begin
			rsp_nxt.status = ST_UNDERFLOW;
		end else begin
			rsp_nxt.status       = ST_POPPED;
			rsp_nxt.popped_value = cell_val[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[sim/sorted_priority_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Self-checking bench for the sorted priority queue. A short table of
// directed transfers (empty pop, priority extremes, equal priorities, full
// queue) is followed by random insert/pop traffic that alternates between
// fill-heavy, drain-heavy and balanced stretches. A mirror of the queue
// predicts all unfixed responses; request and response sides both throttle.
// ----------------------------------------------------------------------------

module sorted_priority_queue_test;

	import spq_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		req_t stim;
		bit   fixed;
		rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	logic signed [31:0] mirror_value [DEPTH];
	logic signed [15:0] mirror_prio [DEPTH];
	int                 mirror_count;

	rsp_t awaited_rsp[$];
	row_t plan[$];
	rsp_t want_rsp;
	int   mismatches;
	int   cycles;
	int   burst_left;
	int   stall_mode;
	int   stall_cycle;

	always #1 clk = ~clk;

	sorted_priority_queue #(
		.CAPACITY(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		int   pos;
		int   i;
		o.status       = ST_INSERTED;
		o.popped_value = '0;
		if (r.kind == KIND_INSERT) begin
			if (mirror_count >= DEPTH) begin
				o.status = ST_OVERFLOW;
			end else begin
				pos = 0;
				while (pos < mirror_count &&
						$signed(mirror_prio[pos]) <= $signed(r.item_priority))
					pos++;
				for (i = mirror_count; i > pos; i--) begin
					mirror_value[i] = mirror_value[i - 1];
					mirror_prio[i]  = mirror_prio[i - 1];
				end
				mirror_value[pos] = r.item_value;
				mirror_prio[pos]  = r.item_priority;
				mirror_count++;
			end
		end else begin
			if (mirror_count == 0) begin
				o.status = ST_UNDERFLOW;
			end else begin
				o.status       = ST_POPPED;
				o.popped_value = mirror_value[0];
				for (i = 1; i < mirror_count; i++) begin
					mirror_value[i - 1] = mirror_value[i];
					mirror_prio[i - 1]  = mirror_prio[i];
				end
				mirror_count--;
			end
		end
		o.occupancy = 5'(mirror_count);
		return o;
	endfunction

	function automatic void add_row(logic kind, logic [31:0] value, logic [15:0] prio,
			bit fixed, status_t st, logic [31:0] popped, logic [4:0] occ);
		row_t row;
		row.stim.kind          = kind;
		row.stim.item_value    = value;
		row.stim.item_priority = prio;
		row.fixed              = fixed;
		row.want.status        = st;
		row.want.popped_value  = popped;
		row.want.occupancy     = occ;
		plan.push_back(row);
	endfunction

	task automatic drive_item(req_t r, bit fixed, rsp_t want);
		rsp_t got;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		got = serve_request(r);
		awaited_rsp.push_back(fixed ? want : got);
		@(negedge clk);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	// response side throttle
	always @(negedge clk) begin
		if (stall_cycle % 50 == 0)
			stall_mode = $urandom_range(0, 2);
		stall_cycle++;
		case (stall_mode)
			0: begin
				rsp_ready <= 1'b1;
			end
			1: begin
				rsp_ready <= ($urandom_range(0, 99) >= 35);
			end
			default: begin
				rsp_ready <= (stall_cycle % 8) >= 5;
			end
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL sorted_priority_queue");
			$finish;
		end else if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: status %0d value %h occupancy %0d",
						rsp.status, rsp.popped_value, rsp.occupancy);
			end else begin
				want_rsp = awaited_rsp.pop_front();
				if (rsp.status !== want_rsp.status ||
						rsp.popped_value !== want_rsp.popped_value ||
						rsp.occupancy !== want_rsp.occupancy) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
							want_rsp.status, want_rsp.popped_value, want_rsp.occupancy,
							rsp.status, rsp.popped_value, rsp.occupancy);
				end
			end
		end
	end

	initial begin
		req_t r;
		int   n;
		int   insert_pct;
		req          = '0;
		req_valid    = 1'b0;
		rsp_ready    = 1'b0;
		arst_n       = 1'b0;
		mirror_count = 0;
		mismatches   = 0;
		cycles       = 0;
		burst_left   = 0;
		stall_mode   = 0;
		stall_cycle  = 0;

		add_row(KIND_POP, 32'h0, 16'h0, 1, ST_UNDERFLOW, 32'h0, 5'd0);
		add_row(KIND_INSERT, 32'h7FFF_FFFF, 16'h7FFF, 1, ST_INSERTED, 32'h0, 5'd1);
		add_row(KIND_INSERT, 32'h8000_0000, 16'h8000, 1, ST_INSERTED, 32'h0, 5'd2);
		add_row(KIND_INSERT, 32'h0, 16'h0, 1, ST_INSERTED, 32'h0, 5'd3);
		// same priority as the entry above, must leave after it
		add_row(KIND_INSERT, 32'hFFFF_FFFF, 16'h0, 1, ST_INSERTED, 32'h0, 5'd4);
		add_row(KIND_POP, 32'hFFFF_FFFF, 16'hFFFF, 1, ST_POPPED, 32'h8000_0000, 5'd3);
		add_row(KIND_POP, 32'h0, 16'h0, 1, ST_POPPED, 32'h0, 5'd2);
		for (n = 0; n < 14; n++)
			add_row(KIND_INSERT, 32'h1111_1111 * n, 16'((n * 5) % 7) - 16'd3, 0,
				ST_INSERTED, 32'h0, 5'd0);
		add_row(KIND_INSERT, 32'h1234_5678, 16'h8000, 1, ST_OVERFLOW, 32'h0, 5'd16);
		add_row(KIND_POP, 32'h0, 16'h0, 0, ST_INSERTED, 32'h0, 5'd0);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			drive_item(plan[i].stim, plan[i].fixed, plan[i].want);
			pace();
		end

		insert_pct = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 15;
					1: insert_pct = 50;
					default: insert_pct = 85;
				endcase
			end
			if (n == RANDOM_ITEMS / 2) begin
				req_valid <= 1'b0;
				wait (awaited_rsp.size() == 0);
				@(negedge clk);
			end
			r.kind          = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP;
			r.item_value    = $urandom;
			r.item_priority = $urandom_range(0, 1) ? 16'($urandom_range(0, 7) - 4)
				: 16'($urandom);
			drive_item(r, 1'b0, '0);
			pace();
		end
		req_valid <= 1'b0;

		wait (awaited_rsp.size() == 0);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && awaited_rsp.size() == 0)
			$display("PASS sorted_priority_queue");
		else
			$display("FAIL sorted_priority_queue");
		$finish;
	end

endmodule
